// ----- hdl/dagr_pkg.sv -----
// shared constants and control types for the deadlock-avoiding resource grant block
package dagr_pkg;

	localparam int PROC_DEF = 8;
	localparam int RES_DEF  = 3;
	localparam int RES_MAX  = 3;

	localparam int CMD_W    = 2;
	localparam int PROC_W   = 3;
	localparam int AMT_W    = 8;
	localparam int STATUS_W = 3;

	localparam logic [CMD_W-1:0] CMD_LOAD_MAX   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_HELD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REQUEST    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXCEEDS  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNSAFE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic undo;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic go_scan;
		logic safe;
		logic unsafe;
	} dp_stat_t;

endpackage

// ----- hdl/dagr_datapath.sv -----
// tables, work vector, safety scan step and result register
module dagr_datapath #(
	parameter int PROCESSES = dagr_pkg::PROC_DEF,
	parameter int RESOURCES = dagr_pkg::RES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dagr_pkg::dp_cmd_t               ctl,
	output dagr_pkg::dp_stat_t              stat,
	input  logic [dagr_pkg::CMD_W-1:0]      cmd,
	input  logic [dagr_pkg::PROC_W-1:0]     process,
	input  logic [dagr_pkg::AMT_W-1:0]      amount [dagr_pkg::RES_MAX],
	output logic [dagr_pkg::STATUS_W-1:0]   status,
	output logic [dagr_pkg::AMT_W-1:0]      avail [dagr_pkg::RES_MAX]
);
	import dagr_pkg::*;

	localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int WORK_W = AMT_W + $clog2(PROCESSES + 1);

	logic [CMD_W-1:0]    cmd_q;
	logic [PROC_W-1:0]   proc_q;
	logic [AMT_W-1:0]    amt_q [RESOURCES];
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [AMT_W-1:0]    out_avail_q [RES_MAX];

	logic [AMT_W-1:0]    avail_q [RESOURCES];
	logic [AMT_W-1:0]    claim_q [PROCESSES][RESOURCES];
	logic [AMT_W-1:0]    held_q [PROCESSES][RESOURCES];
	logic [WORK_W-1:0]   work_q [RESOURCES];
	logic [PROCESSES-1:0] done_q;
	logic [PIDX_W-1:0]   idx_q;
	logic                progress_q;

	logic [PIDX_W-1:0]   pidx;
	logic [PIDX_W-1:0]   rd_idx;
	logic                in_range;
	logic [AMT_W-1:0]    claim_row [RESOURCES];
	logic [AMT_W-1:0]    held_row [RESOURCES];
	logic [AMT_W-1:0]    need [RESOURCES];
	logic [AMT_W-1:0]    avail_full [RES_MAX];
	logic                over_held;
	logic                over_claim;
	logic                exceeds;
	logic                fit_all;
	logic                fits;
	logic                last;
	logic                progress_nx;
	logic                all_done;
	logic [PROCESSES-1:0] done_nx;
	logic [STATUS_W-1:0] exec_status;

	assign pidx     = proc_q[PIDX_W-1:0];
	assign in_range = {1'b0, proc_q} < (PROC_W + 1)'(PROCESSES);
	assign rd_idx   = ctl.scan ? idx_q : pidx;

	always_comb begin
		over_held  = 1'b0;
		over_claim = 1'b0;
		exceeds    = 1'b0;
		fit_all    = 1'b1;
		for (int r = 0; r < RESOURCES; r++) begin
			claim_row[r] = claim_q[rd_idx][r];
			held_row[r]  = held_q[rd_idx][r];
			need[r]      = (claim_row[r] > held_row[r]) ? (claim_row[r] - held_row[r]) : '0;
			if (held_row[r] > amt_q[r])
				over_held = 1'b1;
			if (amt_q[r] > claim_row[r])
				over_claim = 1'b1;
			if (amt_q[r] > need[r] || amt_q[r] > avail_q[r])
				exceeds = 1'b1;
			if (WORK_W'(need[r]) > work_q[r])
				fit_all = 1'b0;
		end
	end

	assign fits        = !done_q[idx_q] && fit_all;
	assign done_nx     = done_q | (PROCESSES'(fits) << idx_q);
	assign progress_nx = progress_q | fits;
	assign all_done    = &done_nx;
	assign last        = (idx_q == PIDX_W'(PROCESSES - 1));

	assign stat.go_scan = (cmd_q == CMD_REQUEST) && in_range && !exceeds;
	assign stat.safe    = all_done;
	assign stat.unsafe  = last && !progress_nx && !all_done;

	always_comb begin
		unique case (cmd_q)
			CMD_LOAD_MAX:   exec_status = (!in_range || over_held) ? ST_REJECTED : ST_LOADED;
			CMD_LOAD_HELD:  exec_status = (!in_range || over_claim) ? ST_REJECTED : ST_LOADED;
			CMD_LOAD_AVAIL: exec_status = ST_LOADED;
			CMD_REQUEST:    exec_status = (!in_range || exceeds) ? ST_EXCEEDS : ST_GRANTED;
			default:        exec_status = ST_LOADED;
		endcase
	end

	for (genvar g = 0; g < RES_MAX; g++) begin : g_avail
		if (g < RESOURCES) begin : g_used
			assign avail_full[g] = avail_q[g];
		end else begin : g_unused
			assign avail_full[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < RESOURCES; r++) begin
				avail_q[r] <= '0;
				work_q[r]  <= '0;
				for (int p = 0; p < PROCESSES; p++) begin
					claim_q[p][r] <= '0;
					held_q[p][r]  <= '0;
				end
			end
			done_q     <= '0;
			idx_q      <= '0;
			progress_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				unique case (cmd_q)
					CMD_LOAD_MAX: begin
						if (in_range && !over_held)
							claim_q[pidx] <= amt_q;
					end
					CMD_LOAD_HELD: begin
						if (in_range && !over_claim)
							held_q[pidx] <= amt_q;
					end
					CMD_LOAD_AVAIL: begin
						avail_q <= amt_q;
					end
					CMD_REQUEST: begin
						if (stat.go_scan) begin
							for (int r = 0; r < RESOURCES; r++) begin
								avail_q[r]      <= avail_q[r] - amt_q[r];
								held_q[pidx][r] <= held_row[r] + amt_q[r];
								work_q[r]       <= WORK_W'(avail_q[r] - amt_q[r]);
							end
							done_q     <= '0;
							idx_q      <= '0;
							progress_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.scan) begin
				if (fits) begin
					for (int r = 0; r < RESOURCES; r++)
						work_q[r] <= work_q[r] + WORK_W'(held_row[r]);
				end
				done_q <= done_nx;
				if (last) begin
					idx_q      <= '0;
					progress_q <= 1'b0;
				end else begin
					idx_q      <= idx_q + PIDX_W'(1);
					progress_q <= progress_nx;
				end
			end
			if (ctl.undo) begin
				for (int r = 0; r < RESOURCES; r++) begin
					avail_q[r]      <= avail_q[r] + amt_q[r];
					held_q[pidx][r] <= held_row[r] - amt_q[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd;
			proc_q <= process;
			for (int r = 0; r < RESOURCES; r++)
				amt_q[r] <= amount[r];
		end
		if (ctl.exec)
			status_q <= exec_status;
		if (ctl.scan && all_done)
			status_q <= ST_GRANTED;
		if (ctl.undo)
			status_q <= ST_UNSAFE;
		if (ctl.emit) begin
			out_status_q <= status_q;
			out_avail_q  <= avail_full;
		end
	end

	assign status = out_status_q;
	assign avail  = out_avail_q;

endmodule

// ----- hdl/dagr_controller.sv -----
// sequencing state machine and handshake control
module dagr_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  dagr_pkg::dp_stat_t stat,
	output dagr_pkg::dp_cmd_t  ctl
);
	import dagr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_UNDO = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;

	assign ctl.capture = in_valid && in_ready;
	assign ctl.exec    = (state_q == S_EXEC);
	assign ctl.scan    = (state_q == S_SCAN);
	assign ctl.undo    = (state_q == S_UNDO);
	assign ctl.emit    = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (ctl.capture) state_nx = S_EXEC;
			S_EXEC: state_nx = stat.go_scan ? S_SCAN : S_EMIT;
			S_SCAN: begin
				if (stat.safe)
					state_nx = S_EMIT;
				else if (stat.unsafe)
					state_nx = S_UNDO;
			end
			S_UNDO: state_nx = S_EMIT;
			S_EMIT: if (ctl.emit) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/deadlock_avoiding_resource_grant_top.sv -----
// top level of the deadlock-avoiding resource grant block
// usage:
//   input channel (in_valid/in_ready) carries cmd, process and amount_0..2;
//   a transfer loads a claim row, an allocation row, the available vector,
//   or asks for a grant on behalf of one process
//   output channel (out_valid/out_ready) returns one result per input transfer:
//   status and the available units after the step
// sequencing:
//   one item is processed at a time; a load or a rejected request passes
//   through the exec and emit steps before out_valid rises, and the next
//   input transfer is taken back in idle; a checked request adds the safety
//   scan (one process row per cycle, up to PROCESSES passes) plus an undo
//   step to back out an unsafe grant
// reset:
//   arst_n clears all tables and the available vector to zero, no result pending
// stall:
//   the result sits in an output register; the next input transfer is taken
//   while it waits, and that item then holds in its final step until the
//   receiver takes the earlier result
module deadlock_avoiding_resource_grant_top #(
	parameter int PROCESSES = dagr_pkg::PROC_DEF,
	parameter int RESOURCES = dagr_pkg::RES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dagr_pkg::CMD_W-1:0]    cmd,
	input  logic [dagr_pkg::PROC_W-1:0]   process,
	input  logic [dagr_pkg::AMT_W-1:0]    amount_0,
	input  logic [dagr_pkg::AMT_W-1:0]    amount_1,
	input  logic [dagr_pkg::AMT_W-1:0]    amount_2,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dagr_pkg::STATUS_W-1:0] status,
	output logic [dagr_pkg::AMT_W-1:0]    avail_0,
	output logic [dagr_pkg::AMT_W-1:0]    avail_1,
	output logic [dagr_pkg::AMT_W-1:0]    avail_2
);
	import dagr_pkg::*;

	dp_cmd_t        ctl;
	dp_stat_t       stat;
	logic [AMT_W-1:0] amount [RES_MAX];
	logic [AMT_W-1:0] avail [RES_MAX];

	assign amount[0] = amount_0;
	assign amount[1] = amount_1;
	assign amount[2] = amount_2;
	assign avail_0   = avail[0];
	assign avail_1   = avail[1];
	assign avail_2   = avail[2];

	dagr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	dagr_datapath #(
		.PROCESSES (PROCESSES),
		.RESOURCES (RESOURCES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.stat    (stat),
		.cmd     (cmd),
		.process (process),
		.amount  (amount),
		.status  (status),
		.avail   (avail)
	);

endmodule
